[design/uart_pkg.sv]
// Package for the 8N1 UART transceiver: frame constants, receiver phase type.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps
`default_nettype none

package uart_pkg;

    localparam int unsigned PERIOD_W     = 16;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned COUNT_W      = 4;
    localparam int unsigned S_TDATA_W    = 16;
    localparam int unsigned M_TDATA_W    = 16;

    localparam logic [COUNT_W-1:0]  FRAME_BITS   = 4'd10;
    localparam logic [COUNT_W-1:0]  DATA_BITS    = 4'd8;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd208;

    typedef enum logic [3:0] {
        RX_IDLE = 4'b0001,
        RX_HALF = 4'b0010,
        RX_DATA = 4'b0100,
        RX_STOP = 4'b1000
    } rx_phase_t;

endpackage

`default_nettype wire

[design/uart_8n1_transceiver_top.sv]
// 8N1 UART transceiver top level; one input word is one tick of line sampling.
// The result word of an accepted input word is registered and shown in the next cycle.
// Throughput: one word per cycle unless m_tready stalls; the output register frees itself when m_tready is high.
// Reset: synchronous active-low aresetn clears the transmitter to idle-high,
// the receiver to waiting for a start bit, and the bit period to 208 ticks.
// Depends on uart_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uart_8n1_transceiver_top (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               cfg_wr_en,
    input  wire [uart_pkg::PERIOD_W-1:0]      cfg_wr_data,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0: rx_line, tx_request, tx_byte[7:0], zero padding.
    input  wire [uart_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // Fields from bit 0: tx_line, tx_busy, rx_valid, rx_byte[7:0], zero padding.
    output logic [uart_pkg::M_TDATA_W-1:0]    m_tdata
);
    import uart_pkg::*;

    logic [PERIOD_W-1:0] period_reg;

    logic [BYTE_W-1:0]   tx_shift_reg, tx_shift_next;
    logic [COUNT_W-1:0]  tx_left_reg, tx_left_next;
    logic [PERIOD_W-1:0] tx_timer_reg, tx_timer_next;
    logic                tx_level_reg, tx_level_next;

    rx_phase_t           rx_phase_reg, rx_phase_next;
    logic [PERIOD_W-1:0] rx_timer_reg, rx_timer_next;
    logic [COUNT_W-1:0]  rx_left_reg, rx_left_next;
    logic [BYTE_W-1:0]   rx_shift_reg, rx_shift_next;

    logic                out_valid_reg;
    logic                out_tx_line_reg, out_tx_busy_reg, out_rx_valid_reg;
    logic [BYTE_W-1:0]   out_rx_byte_reg;
    logic                rx_valid_next;
    logic [BYTE_W-1:0]   rx_byte_next;

    logic                in_line, in_req;
    logic [BYTE_W-1:0]   in_byte;
    logic                accept;
    logic [PERIOD_W-1:0] tx_dec, rx_dec;

    assign in_line  = s_tdata[0];
    assign in_req   = s_tdata[1];
    assign in_byte  = s_tdata[BYTE_W+1:2];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign tx_dec = (tx_timer_reg != '0) ? tx_timer_reg - 1'b1 : '0;
    assign rx_dec = (rx_timer_reg != '0) ? rx_timer_reg - 1'b1 : '0;

    always_comb begin
        tx_shift_next = tx_shift_reg;
        tx_left_next  = tx_left_reg;
        tx_timer_next = tx_timer_reg;
        tx_level_next = tx_level_reg;
        if (tx_left_reg != '0) begin
            if (tx_dec == '0) begin
                tx_level_next = tx_shift_reg[0];
                tx_shift_next = {1'b1, tx_shift_reg[BYTE_W-1:1]};
                tx_left_next  = tx_left_reg - 1'b1;
                tx_timer_next = (tx_left_next != '0) ? period_reg : '0;
            end else begin
                tx_timer_next = tx_dec;
            end
        end
        if (tx_left_next == '0 && in_req) begin
            tx_level_next = 1'b0;
            tx_shift_next = in_byte;
            tx_left_next  = FRAME_BITS;
            tx_timer_next = period_reg;
        end
    end

    always_comb begin
        rx_phase_next = rx_phase_reg;
        rx_timer_next = rx_timer_reg;
        rx_left_next  = rx_left_reg;
        rx_shift_next = rx_shift_reg;
        rx_valid_next = 1'b0;
        rx_byte_next  = '0;
        case (rx_phase_reg)
            RX_IDLE: begin
                if (!in_line) begin
                    rx_phase_next = RX_HALF;
                    rx_timer_next = period_reg >> 1;
                    rx_shift_next = '0;
                    rx_left_next  = '0;
                end
            end
            RX_HALF: begin
                rx_timer_next = rx_dec;
                if (rx_dec == '0) begin
                    rx_phase_next = RX_DATA;
                    rx_left_next  = DATA_BITS;
                    rx_timer_next = period_reg;
                end
            end
            RX_DATA: begin
                rx_timer_next = rx_dec;
                if (rx_dec == '0) begin
                    rx_shift_next = {in_line, rx_shift_reg[BYTE_W-1:1]};
                    rx_left_next  = (rx_left_reg != '0) ? rx_left_reg - 1'b1 : '0;
                    if (rx_left_next == '0) begin
                        rx_phase_next = RX_STOP;
                    end
                    rx_timer_next = period_reg;
                end
            end
            RX_STOP: begin
                rx_timer_next = rx_dec;
                if (rx_dec == '0) begin
                    rx_valid_next = 1'b1;
                    rx_byte_next  = rx_shift_reg;
                    rx_phase_next = RX_IDLE;
                    rx_timer_next = '0;
                end
            end
            default: begin
                rx_phase_next = RX_IDLE;
                rx_timer_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= PERIOD_RESET;
            tx_shift_reg  <= '1;
            tx_left_reg   <= '0;
            tx_timer_reg  <= '0;
            tx_level_reg  <= 1'b1;
            rx_phase_reg  <= RX_IDLE;
            rx_timer_reg  <= '0;
            rx_left_reg   <= '0;
            rx_shift_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                period_reg <= cfg_wr_data;
            end
            if (accept) begin
                tx_shift_reg <= tx_shift_next;
                tx_left_reg  <= tx_left_next;
                tx_timer_reg <= tx_timer_next;
                tx_level_reg <= tx_level_next;
                rx_phase_reg <= rx_phase_next;
                rx_timer_reg <= rx_timer_next;
                rx_left_reg  <= rx_left_next;
                rx_shift_reg <= rx_shift_next;
            end
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_tx_line_reg  <= tx_level_next;
            out_tx_busy_reg  <= (tx_left_next != '0);
            out_rx_valid_reg <= rx_valid_next;
            out_rx_byte_reg  <= rx_byte_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-BYTE_W-3){1'b0}}, out_rx_byte_reg,
                       out_rx_valid_reg, out_tx_busy_reg, out_tx_line_reg};

endmodule

`default_nettype wire

[design/uart_8n1_transceiver_checker.sv]
// Port-level checker for the 8N1 UART transceiver, bound to its top level.
// Depends on uart_pkg and uart_8n1_transceiver_top.
`timescale 1ns / 1ps
`default_nettype none

module uart_8n1_transceiver_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [uart_pkg::M_TDATA_W-1:0]  m_tdata
);
    import uart_pkg::*;

    // A result word waiting downstream holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The block never stalls its input when no result word is pending.
    a_ready: assert property (@(posedge aclk) !m_tvalid |-> s_tready)
        else $error("input stalled with empty output register");

    // A received byte field reads zero unless a byte is reported.
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[2] |-> m_tdata[BYTE_W+2:3] == '0)
        else $error("rx_byte nonzero without rx_valid");

    // The receiver is idle right after a byte report, so two words in a row never both
    // report a byte.
    a_valid_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tdata[2] |=> !(m_tvalid && m_tdata[2]))
        else $error("rx_valid reported on consecutive words");

    // Leaving reset, no stale result word is shown.
    a_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result word visible right after reset");

endmodule

bind uart_8n1_transceiver_top uart_8n1_transceiver_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[dv/uart_8n1_transceiver_top_tb.sv]
// Self-checking testbench for uart_8n1_transceiver_top: a stimulus table, then random
// loopback, framed and noisy line ticks, checked per word against a tick model or typed pins.
// Depends on uart_pkg and the top level in design/.
`timescale 1ns / 1ps

module uart_8n1_transceiver_top_tb;
    import uart_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_request;
        logic       rx_line;
    } tick_word_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_busy;
        logic       tx_line;
    } pin_word_t;

    typedef struct packed {
        logic        wr;
        logic [15:0] period;
        logic        line;
        logic        req;
        logic [7:0]  byt;
        logic        typed;
        pin_word_t   pins;
    } probe_t;

    localparam int ITEMS       = 790;
    localparam int QUIET_AT    = 670;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG    = 2000;
    localparam int NPROBES     = 24;

    localparam pin_word_t IDLE_PINS  = '{rx_byte: 8'h00, rx_valid: 1'b0, tx_busy: 1'b0,
                                         tx_line: 1'b1};
    localparam pin_word_t START_PINS = '{rx_byte: 8'h00, rx_valid: 1'b0, tx_busy: 1'b1,
                                         tx_line: 1'b0};
    localparam pin_word_t NO_PINS    = '0;

    localparam probe_t PROBES [NPROBES] = '{
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b1, IDLE_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'hFF, 1'b1, IDLE_PINS},
        '{1'b1, 16'd0, 1'b1, 1'b1, 8'hFF, 1'b1, START_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b1, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b0, 8'h00, 1'b0, NO_PINS},
        '{1'b1, 16'd1, 1'b0, 1'b1, 8'h00, 1'b1, START_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b1, 8'h5A, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b1, 8'hA5, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b1, 8'hFF, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b1, 8'h00, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b1, 8'h3C, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b1, 8'hC3, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b0, 1'b1, 8'h81, 1'b0, NO_PINS},
        '{1'b0, 16'd0, 1'b1, 1'b1, 8'h7E, 1'b0, NO_PINS}
    };

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [PERIOD_W-1:0]  cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    logic                 m_tready    = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire [M_TDATA_W-1:0]  m_tdata;

    logic [PERIOD_W-1:0] period_q;
    logic [7:0]          tx_sr;
    logic [3:0]          tx_left;
    logic [15:0]         tx_tmr;
    logic                tx_lvl;
    rx_phase_t           rx_ph;
    logic [15:0]         rx_tmr;
    logic [3:0]          rx_left;
    logic [7:0]          rx_sr;

    pin_word_t pin_states_q [$];
    logic      wave_q [$];

    int  mismatches     = 0;
    int  idle_run       = 0;
    int  items_sent     = 0;
    int  bytes_received = 0;
    int  frames_started = 0;
    bit  quiet          = 1'b0;
    bit  hold_req       = 1'b0;

    uart_8n1_transceiver_top u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic pin_word_t uart_tick(input tick_word_t t);
        pin_word_t p;
        p = '0;
        if (tx_left != 0) begin
            if (tx_tmr != 0) tx_tmr = tx_tmr - 1'b1;
            if (tx_tmr == 0) begin
                tx_lvl  = tx_sr[0];
                tx_sr   = {1'b1, tx_sr[7:1]};
                tx_left = tx_left - 1'b1;
                tx_tmr  = (tx_left != 0) ? period_q : '0;
            end
        end
        if (tx_left == 0 && t.tx_request) begin
            tx_lvl  = 1'b0;
            tx_sr   = t.tx_byte;
            tx_left = FRAME_BITS;
            tx_tmr  = period_q;
            frames_started++;
        end
        if (rx_ph == RX_IDLE) begin
            if (!t.rx_line) begin
                rx_ph   = RX_HALF;
                rx_tmr  = period_q >> 1;
                rx_sr   = '0;
                rx_left = '0;
            end
        end else begin
            if (rx_tmr != 0) rx_tmr = rx_tmr - 1'b1;
            if (rx_tmr == 0) begin
                case (rx_ph)
                    RX_HALF: begin
                        rx_ph   = RX_DATA;
                        rx_left = DATA_BITS;
                        rx_tmr  = period_q;
                    end
                    RX_DATA: begin
                        rx_sr = {t.rx_line, rx_sr[7:1]};
                        if (rx_left != 0) rx_left = rx_left - 1'b1;
                        if (rx_left == 0) rx_ph = RX_STOP;
                        rx_tmr = period_q;
                    end
                    default: begin
                        p.rx_valid = 1'b1;
                        p.rx_byte  = rx_sr;
                        rx_ph      = RX_IDLE;
                        rx_tmr     = '0;
                    end
                endcase
            end
        end
        p.tx_line = tx_lvl;
        p.tx_busy = (tx_left != 0);
        return p;
    endfunction

    function automatic tick_word_t mk_tick(input logic line, input logic req,
                                           input logic [7:0] byt);
        tick_word_t t;
        t.rx_line    = line;
        t.tx_request = req;
        t.tx_byte    = byt;
        return t;
    endfunction

    task automatic put_word(input tick_word_t t, input bit typed, input pin_word_t typed_pins);
        pin_word_t p;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(t);
        do @(posedge aclk); while (!s_tready);
        p = uart_tick(t);
        pin_states_q.push_back(typed ? typed_pins : p);
        items_sent++;
        if (p.rx_valid) bytes_received++;
    endtask

    task automatic set_period(input logic [PERIOD_W-1:0] v);
        s_tvalid <= 1'b0;
        while (pin_states_q.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        period_q = v;
    endtask

    task automatic push_level(input logic level, input int count);
        repeat (count) wave_q.push_back(level);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        pin_word_t got;
        pin_word_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_run = 0;
            else idle_run++;
            if (m_tvalid && m_tready) begin
                got = pin_word_t'(m_tdata[10:0]);
                check_field("padding", 0, m_tdata[M_TDATA_W-1:11]);
                if (pin_states_q.size() == 0) begin
                    $error("result word arrived with no expectation waiting");
                    mismatches++;
                end else begin
                    want = pin_states_q.pop_front();
                    check_field("tx_line", want.tx_line, got.tx_line);
                    check_field("tx_busy", want.tx_busy, got.tx_busy);
                    check_field("rx_valid", want.rx_valid, got.rx_valid);
                    check_field("rx_byte", want.rx_byte, got.rx_byte);
                end
            end
        end
    end

    always begin
        @(posedge aclk);
        if (hold_req) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_req = 1'b0;
        end else if (aresetn && !quiet && $urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        m_tready <= 1'b1;
    end

    initial begin
        wait (aresetn);
        while (idle_run < WATCHDOG) @(posedge aclk);
        $display("simulation failed");
        $finish;
    end

    initial begin
        int         phase;
        int         mode;
        int         n;
        int         pe;
        int         r;
        logic [7:0] b;
        logic [PERIOD_W-1:0] p;

        period_q = PERIOD_RESET;
        tx_sr    = 8'hFF;
        tx_left  = '0;
        tx_tmr   = '0;
        tx_lvl   = 1'b1;
        rx_ph    = RX_IDLE;
        rx_tmr   = '0;
        rx_left  = '0;
        rx_sr    = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NPROBES; i++) begin
            if (PROBES[i].wr) set_period(PROBES[i].period);
            put_word(mk_tick(PROBES[i].line, PROBES[i].req, PROBES[i].byt),
                     PROBES[i].typed, PROBES[i].pins);
        end

        phase = 0;
        while (items_sent < ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0) p = PERIOD_W'($urandom_range(0, 1));
            else if (r == 1) p = PERIOD_W'($urandom_range(7, 24));
            else p = PERIOD_W'($urandom_range(2, 6));
            set_period(p);
            if (items_sent >= QUIET_AT) quiet = 1'b1;
            mode = $urandom_range(0, 19);
            if (phase == 2) begin
                hold_req = 1'b1;
                mode = 0;
            end
            if (mode < 8) begin
                // The transmit pin is fed back to the receive pin.
                n = $urandom_range(60, 140);
                repeat (n) put_word(mk_tick(tx_lvl, $urandom_range(0, 4) == 0,
                                            8'($urandom_range(0, 255))), 1'b0, NO_PINS);
            end else if (mode < 17) begin
                pe = (p < 2) ? 1 : int'(p);
                n = (pe > 8) ? 1 : $urandom_range(2, 4);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    push_level(1'b1, $urandom_range(0, 3));
                    if ($urandom_range(0, 7) == 0) begin
                        push_level(1'b0, 1);
                        push_level(1'b1, pe - 1);
                    end else begin
                        push_level(1'b0, pe);
                    end
                    for (int k = 0; k < 8; k++) push_level(b[k], pe);
                    if ($urandom_range(0, 5) == 0) push_level(1'b0, pe);
                    else push_level(1'b1, pe * int'($urandom_range(1, 2)));
                end
                while (wave_q.size() != 0)
                    put_word(mk_tick(wave_q.pop_front(), $urandom_range(0, 5) == 0,
                                     8'($urandom_range(0, 255))), 1'b0, NO_PINS);
            end else begin
                n = $urandom_range(20, 60);
                repeat (n) put_word(mk_tick($urandom_range(0, 3) != 0,
                                            1'($urandom_range(0, 1)),
                                            8'($urandom_range(0, 255))), 1'b0, NO_PINS);
            end
            phase++;
        end

        set_period(16'hFFFF);
        put_word(mk_tick(1'b0, 1'b1, 8'($urandom_range(0, 255))), 1'b0, NO_PINS);
        repeat (11) put_word(mk_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                     8'($urandom_range(0, 255))), 1'b0, NO_PINS);

        s_tvalid <= 1'b0;
        while (pin_states_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        $display("Checked %0d tick words over %0d random phases.", items_sent, phase);
        $display("Frames started: %0d, bytes received: %0d, bit periods 0 to 65535.",
                 frames_started, bytes_received);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
